// ----- rtl/core/bfs_pkg.sv -----
// shared types and codes for the breadth-first path finder
package bfs_pkg;

    localparam int NODE_W   = 6;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_INIT     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_VERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [NODE_W-1:0] node_t;

endpackage

// ----- rtl/core/bfs_tree_path_finder.sv -----
// breadth-first search path finder over a stored directed graph
//
//  channel | dir | handshake        | beat contents
//  s_      | in  | tvalid / tready  | tdata: command, node_a, node_b
//  m_      | out | tvalid / tready  | tdata: path_node, status; tlast ends command
//
// a build command is decoded and answered before the next accept; a search reads each queued vertex,
// its degree and each adjacency entry, then walks the predecessors back onto a stack and sends the path
// out from it; every read of the adjacency, degree, queue, predecessor and stack memories is registered.
// aresetn clears the graph (no vertices, all lists empty); memory contents need no clearing.
// one command at a time; a stalled m_ side holds the walk at the next beat.
module bfs_tree_path_finder #(
    parameter int MAX_NODES  = 64,
    parameter int MAX_DEGREE = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] command, [7:2] node_a, [13:8] node_b, zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] path_node, [7:6] status
    output logic        m_tlast
);

    localparam int NW        = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW        = $clog2(MAX_NODES + 1);
    localparam int DGW       = $clog2(MAX_DEGREE + 1);
    localparam int ADJ_DEPTH = MAX_NODES * MAX_DEGREE;
    localparam int AW        = (ADJ_DEPTH > 1) ? $clog2(ADJ_DEPTH) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_QRD  = 4'd2;
    localparam logic [3:0] S_QWT  = 4'd3;
    localparam logic [3:0] S_DWT  = 4'd4;
    localparam logic [3:0] S_ARD  = 4'd5;
    localparam logic [3:0] S_AWT  = 4'd6;
    localparam logic [3:0] S_BTR  = 4'd7;
    localparam logic [3:0] S_BTW  = 4'd8;
    localparam logic [3:0] S_PRD  = 4'd9;
    localparam logic [3:0] S_PWT  = 4'd10;

    // memories
    bfs_pkg::node_t   adj_mem   [ADJ_DEPTH];
    logic [DGW-1:0]   deg_mem   [MAX_NODES];
    logic [NW-1:0]    pred_mem  [MAX_NODES];
    bfs_pkg::node_t   queue_mem [MAX_NODES];
    bfs_pkg::node_t   stack_mem [MAX_NODES];

    logic                  adj_we, adj_re;
    logic [AW-1:0]         adj_waddr, adj_raddr;
    bfs_pkg::node_t        adj_wdata, adj_rdata_reg;
    logic                  deg_we, deg_re;
    logic [NW-1:0]         deg_waddr, deg_raddr;
    logic [DGW-1:0]        deg_wdata, deg_rdata_reg;
    logic                  deg_rvld_reg;
    logic                  pred_we, pred_re;
    logic [NW-1:0]         pred_waddr, pred_raddr, pred_wdata, pred_rdata_reg;
    logic                  q_we, q_re;
    logic [NW-1:0]         q_waddr, q_raddr;
    bfs_pkg::node_t        q_wdata, q_rdata_reg;
    logic                  st_we, st_re;
    logic [NW-1:0]         st_waddr, st_raddr;
    bfs_pkg::node_t        st_wdata, st_rdata_reg;

    // control registers
    logic [3:0]              state_reg, state_next;
    logic [bfs_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    bfs_pkg::node_t          a_reg, a_next, b_reg, b_next;
    logic [CW-1:0]           vcount_reg, vcount_next;
    logic [MAX_NODES-1:0]    deg_vld_reg, deg_vld_next;
    logic [MAX_NODES-1:0]    disc_reg, disc_next;
    logic [MAX_NODES-1:0]    pv_reg, pv_next;
    logic [CW-1:0]           head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]           len_reg, len_next;
    bfs_pkg::node_t          v_reg, v_next, cur_reg, cur_next;
    logic [DGW-1:0]          degv_reg, degv_next, k_reg, k_next;
    logic                    out_valid_reg, out_valid_next;
    bfs_pkg::node_t          out_node_reg, out_node_next;
    logic                    out_last_reg, out_last_next;
    logic [bfs_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    logic            out_free;
    logic [DGW-1:0]  deg_eff;
    bfs_pkg::node_t  w;
    logic            a_big, a_oor, b_oor;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_status_reg, out_node_reg};
    assign m_tlast  = out_last_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign deg_eff  = deg_rvld_reg ? deg_rdata_reg : '0;
    assign w        = adj_rdata_reg;
    assign a_big    = {1'b0, a_reg} >= 7'(MAX_NODES);
    assign a_oor    = {1'b0, a_reg} >= 7'(vcount_reg) || a_big;
    assign b_oor    = {1'b0, b_reg} >= 7'(vcount_reg) || ({1'b0, b_reg} >= 7'(MAX_NODES));

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        vcount_next     = vcount_reg;
        deg_vld_next    = deg_vld_reg;
        disc_next       = disc_reg;
        pv_next         = pv_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        len_next        = len_reg;
        v_next          = v_reg;
        cur_next        = cur_reg;
        degv_next       = degv_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_node_next   = out_node_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;

        adj_we = 1'b0; adj_waddr = '0; adj_wdata = '0; adj_re = 1'b0; adj_raddr = '0;
        deg_we = 1'b0; deg_waddr = '0; deg_wdata = '0; deg_re = 1'b0; deg_raddr = '0;
        pred_we = 1'b0; pred_waddr = '0; pred_wdata = '0; pred_re = 1'b0; pred_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_re = 1'b0; q_raddr = '0;
        st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_re = 1'b0; st_raddr = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tdata[1:0];
                    a_next     = s_tdata[7:2];
                    b_next     = s_tdata[13:8];
                    deg_re     = 1'b1;
                    deg_raddr  = s_tdata[NW+1:2];
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_node_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = bfs_pkg::ST_OK;
                    state_next      = S_IDLE;
                    case (cmd_reg)
                        bfs_pkg::CMD_INIT: begin
                            if (a_big) begin
                                out_status_next = bfs_pkg::ST_RANGE;
                            end else begin
                                deg_vld_next = '0;
                                vcount_next  = CW'(1);
                            end
                        end
                        bfs_pkg::CMD_ADD_VERT: begin
                            if (a_big) begin
                                out_status_next = bfs_pkg::ST_RANGE;
                            end else begin
                                if (vcount_reg < CW'(MAX_NODES)) begin
                                    vcount_next = vcount_reg + CW'(1);
                                end
                                deg_vld_next[a_reg[NW-1:0]] = 1'b0;
                            end
                        end
                        bfs_pkg::CMD_ADD_EDGE: begin
                            if (a_oor || b_oor) begin
                                out_status_next = bfs_pkg::ST_RANGE;
                            end else if (deg_eff >= DGW'(MAX_DEGREE)) begin
                                out_status_next = bfs_pkg::ST_FULL;
                            end else begin
                                adj_we    = 1'b1;
                                adj_waddr = AW'(32'(a_reg) * MAX_DEGREE + 32'(deg_eff));
                                adj_wdata = b_reg;
                                deg_we    = 1'b1;
                                deg_waddr = a_reg[NW-1:0];
                                deg_wdata = deg_eff + DGW'(1);
                                deg_vld_next[a_reg[NW-1:0]] = 1'b1;
                            end
                        end
                        default: begin
                            if (a_oor || b_oor) begin
                                out_status_next = bfs_pkg::ST_RANGE;
                            end else begin
                                out_valid_next = out_valid_reg && !m_tready;
                                disc_next      = '0;
                                disc_next[a_reg[NW-1:0]] = 1'b1;
                                pv_next        = '0;
                                q_we           = 1'b1;
                                q_waddr        = '0;
                                q_wdata        = a_reg;
                                head_next      = '0;
                                tail_next      = CW'(1);
                                state_next     = S_QRD;
                            end
                        end
                    endcase
                end
            end
            S_QRD: begin
                if (head_reg == tail_reg) begin
                    cur_next   = b_reg;
                    len_next   = '0;
                    state_next = S_BTR;
                end else begin
                    q_re       = 1'b1;
                    q_raddr    = head_reg[NW-1:0];
                    head_next  = head_reg + CW'(1);
                    state_next = S_QWT;
                end
            end
            S_QWT: begin
                v_next     = q_rdata_reg;
                deg_re     = 1'b1;
                deg_raddr  = q_rdata_reg[NW-1:0];
                state_next = S_DWT;
            end
            S_DWT: begin
                degv_next  = deg_eff;
                k_next     = '0;
                state_next = S_ARD;
            end
            S_ARD: begin
                if (k_reg >= degv_reg || k_reg >= DGW'(MAX_DEGREE)) begin
                    state_next = S_QRD;
                end else begin
                    adj_re     = 1'b1;
                    adj_raddr  = AW'(32'(v_reg) * MAX_DEGREE + 32'(k_reg));
                    k_next     = k_reg + DGW'(1);
                    state_next = S_AWT;
                end
            end
            S_AWT: begin
                // stale neighbors beyond the vertex count are skipped
                if ({1'b0, w} < 7'(vcount_reg) && {1'b0, w} < 7'(MAX_NODES)
                        && tail_reg < CW'(MAX_NODES)) begin
                    if (!disc_reg[w[NW-1:0]]) begin
                        disc_next[w[NW-1:0]] = 1'b1;
                        pv_next[w[NW-1:0]]   = 1'b1;
                        pred_we    = 1'b1;
                        pred_waddr = w[NW-1:0];
                        pred_wdata = v_reg[NW-1:0];
                        q_we       = 1'b1;
                        q_waddr    = tail_reg[NW-1:0];
                        q_wdata    = w;
                        tail_next  = tail_reg + CW'(1);
                    end
                end
                state_next = S_ARD;
            end
            S_BTR: begin
                st_we    = 1'b1;
                st_waddr = len_reg[NW-1:0];
                st_wdata = cur_reg;
                len_next = len_reg + CW'(1);
                if (!pv_reg[cur_reg[NW-1:0]] || len_reg + CW'(1) >= CW'(MAX_NODES)) begin
                    state_next = S_PRD;
                end else begin
                    pred_re    = 1'b1;
                    pred_raddr = cur_reg[NW-1:0];
                    state_next = S_BTW;
                end
            end
            S_BTW: begin
                cur_next   = bfs_pkg::node_t'(pred_rdata_reg);
                state_next = S_BTR;
            end
            S_PRD: begin
                st_re      = 1'b1;
                st_raddr   = NW'(len_reg - CW'(1));
                len_next   = len_reg - CW'(1);
                state_next = S_PWT;
            end
            S_PWT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_node_next   = st_rdata_reg;
                    out_last_next   = (len_reg == '0);
                    out_status_next = bfs_pkg::ST_OK;
                    state_next      = (len_reg == '0) ? S_IDLE : S_PRD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            vcount_reg    <= '0;
            deg_vld_reg   <= '0;
            disc_reg      <= '0;
            pv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            deg_vld_reg   <= deg_vld_next;
            disc_reg      <= disc_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
        cmd_reg        <= cmd_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        head_reg       <= head_next;
        tail_reg       <= tail_next;
        len_reg        <= len_next;
        v_reg          <= v_next;
        cur_reg        <= cur_next;
        degv_reg       <= degv_next;
        k_reg          <= k_next;
        out_node_reg   <= out_node_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge aclk) begin
        if (adj_we) begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re) begin
            adj_rdata_reg <= adj_mem[adj_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (deg_we) begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        if (deg_re) begin
            deg_rdata_reg <= deg_mem[deg_raddr];
            deg_rvld_reg  <= deg_vld_reg[deg_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pred_we) begin
            pred_mem[pred_waddr] <= pred_wdata;
        end
        if (pred_re) begin
            pred_rdata_reg <= pred_mem[pred_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (q_re) begin
            q_rdata_reg <= queue_mem[q_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            stack_mem[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            st_rdata_reg <= stack_mem[st_raddr];
        end
    end

endmodule

// ----- test/bfs_tree_path_finder_tb.sv -----
// testbench for the breadth-first path finder: random graph builds and searches checked beat by beat
`timescale 1ns / 100ps

module bfs_tree_path_finder_tb;

    localparam int MAX_NODES  = 64;
    localparam int MAX_DEGREE = 8;
    localparam logic [6:0] NO_PRED = 7'd127;
    localparam int IDLE_LIMIT = 20000;
    localparam int ITEMS      = 480;

    typedef struct packed {
        bfs_pkg::node_t               path_node;
        logic                         last;
        logic [bfs_pkg::STATUS_W-1:0] status;
    } path_beat_t;

    class path_scoreboard;
        path_beat_t     pending[$];
        bfs_pkg::node_t adj[MAX_NODES][MAX_DEGREE];
        int             degree[MAX_NODES];
        int             vertices;
        int             errors;

        function new();
            vertices = 0;
            errors = 0;
            foreach (degree[i]) degree[i] = 0;
        endfunction

        function void push_single(logic [bfs_pkg::STATUS_W-1:0] st);
            path_beat_t b;
            b.path_node = '0;
            b.last = 1'b1;
            b.status = st;
            pending.insert(pending.size(), b);
        endfunction

        function void search_path(int start, int goal);
            bit   seen[MAX_NODES];
            logic [6:0] pred[MAX_NODES];
            int   bfs_q[$];
            int   route[$];
            int   v, w, cur;
            path_beat_t b;
            foreach (seen[i]) begin
                seen[i] = 0;
                pred[i] = NO_PRED;
            end
            bfs_q.insert(bfs_q.size(), start);
            seen[start] = 1;
            while (bfs_q.size() > 0) begin
                v = bfs_q.pop_front();
                for (int k = 0; k < degree[v]; k++) begin
                    w = adj[v][k];
                    if (w >= vertices) continue;
                    if (!seen[w]) begin
                        seen[w] = 1;
                        pred[w] = 7'(v);
                        bfs_q.insert(bfs_q.size(), w);
                    end
                end
            end
            cur = goal;
            while (route.size() < MAX_NODES) begin
                route.push_front(cur);
                if (pred[cur] == NO_PRED) break;
                cur = pred[cur];
            end
            foreach (route[i]) begin
                b.path_node = bfs_pkg::node_t'(route[i]);
                b.last = (i == route.size() - 1);
                b.status = bfs_pkg::ST_OK;
                pending.insert(pending.size(), b);
            end
        endfunction

        function void note_command(logic [bfs_pkg::CMD_W-1:0] cmd, bfs_pkg::node_t a,
                                   bfs_pkg::node_t b);
            case (cmd)
                bfs_pkg::CMD_INIT: begin
                    foreach (degree[i]) degree[i] = 0;
                    vertices = 1;
                    push_single(bfs_pkg::ST_OK);
                end
                bfs_pkg::CMD_ADD_VERT: begin
                    if (vertices < MAX_NODES) vertices++;
                    degree[a] = 0;
                    push_single(bfs_pkg::ST_OK);
                end
                bfs_pkg::CMD_ADD_EDGE: begin
                    if (a >= vertices || b >= vertices) push_single(bfs_pkg::ST_RANGE);
                    else if (degree[a] >= MAX_DEGREE) push_single(bfs_pkg::ST_FULL);
                    else begin
                        adj[a][degree[a]] = b;
                        degree[a]++;
                        push_single(bfs_pkg::ST_OK);
                    end
                end
                default: begin
                    if (a >= vertices || b >= vertices) push_single(bfs_pkg::ST_RANGE);
                    else search_path(a, b);
                end
            endcase
        endfunction

        function void check_beat(logic [7:0] data, logic last);
            path_beat_t e;
            if (pending.size() == 0) begin
                $error("unexpected beat data=%h last=%b", data, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[5:0] !== e.path_node) begin
                $error("path_node expected %0d actual %0d", e.path_node, data[5:0]);
                errors++;
            end
            if (last !== e.last) begin
                $error("last expected %0d actual %0d", e.last, last);
                errors++;
            end
            if (data[7:6] !== e.status) begin
                $error("status expected %0d actual %0d", e.status, data[7:6]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    path_scoreboard sb = new();
    int   idle_cycles = 0;
    int   graph_size = 0;
    int   accepted = 0;

    bfs_tree_path_finder #(.MAX_NODES(MAX_NODES), .MAX_DEGREE(MAX_DEGREE)) uut (.*);

    always #4 aclk = ~aclk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // tvalid stays high into the next beat when there is no gap
    task automatic send_command(logic [bfs_pkg::CMD_W-1:0] cmd, bfs_pkg::node_t a,
                                bfs_pkg::node_t b);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, b, a, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_command(cmd, a, b);
    endtask

    // a node inside the graph most of the time, anything now and then
    function automatic bfs_pkg::node_t pick_node();
        if (graph_size > 0 && $urandom_range(0, 9) != 0)
            return bfs_pkg::node_t'($urandom_range(0, graph_size - 1));
        return bfs_pkg::node_t'($urandom_range(0, 63));
    endfunction

    task automatic build_graph(int n, int edges);
        send_command(bfs_pkg::CMD_INIT, bfs_pkg::node_t'($urandom_range(0, 63)),
                     bfs_pkg::node_t'($urandom_range(0, 63)));
        graph_size = 1;
        for (int i = 1; i < n; i++) begin
            send_command(bfs_pkg::CMD_ADD_VERT, bfs_pkg::node_t'(i),
                         bfs_pkg::node_t'($urandom_range(0, 63)));
            graph_size = (graph_size < MAX_NODES) ? graph_size + 1 : graph_size;
        end
        for (int i = 0; i < edges; i++)
            send_command(bfs_pkg::CMD_ADD_EDGE, pick_node(), pick_node());
    endtask

    // result side with random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
            m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 15) == 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge aclk) if (s_tvalid && s_tready) accepted <= accepted + 1;

    initial begin
        int n;
        int cmds;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty graph errors, a chain, out-of-range edges, seven self edges on one list, reach cases
        send_command(bfs_pkg::CMD_ADD_EDGE, 6'd0, 6'd0);
        send_command(bfs_pkg::CMD_FIND, 6'd0, 6'd0);
        send_command(bfs_pkg::CMD_INIT, 6'd63, 6'd63);
        send_command(bfs_pkg::CMD_ADD_VERT, 6'd1, 6'd0);
        send_command(bfs_pkg::CMD_ADD_VERT, 6'd2, 6'd0);
        send_command(bfs_pkg::CMD_ADD_VERT, 6'd3, 6'd0);
        send_command(bfs_pkg::CMD_ADD_EDGE, 6'd0, 6'd1);
        send_command(bfs_pkg::CMD_ADD_EDGE, 6'd1, 6'd2);
        send_command(bfs_pkg::CMD_ADD_EDGE, 6'd0, 6'd2);
        send_command(bfs_pkg::CMD_ADD_EDGE, 6'd3, 6'd63);
        send_command(bfs_pkg::CMD_ADD_EDGE, 6'd63, 6'd3);
        for (int i = 0; i < 7; i++) send_command(bfs_pkg::CMD_ADD_EDGE, 6'd2, 6'd2);
        send_command(bfs_pkg::CMD_FIND, 6'd0, 6'd2);
        send_command(bfs_pkg::CMD_FIND, 6'd0, 6'd3);
        send_command(bfs_pkg::CMD_FIND, 6'd1, 6'd1);
        send_command(bfs_pkg::CMD_FIND, 6'd0, 6'd63);
        // re-adding vertex 2 empties its list and grows the count
        send_command(bfs_pkg::CMD_ADD_VERT, 6'd2, 6'd0);
        send_command(bfs_pkg::CMD_FIND, 6'd0, 6'd3);

        // full graph: long chain exercising the path depth and count saturation
        build_graph(64, 0);
        send_command(bfs_pkg::CMD_ADD_VERT, 6'd10, 6'd0);
        for (int i = 0; i < 63; i++)
            send_command(bfs_pkg::CMD_ADD_EDGE, bfs_pkg::node_t'(i), bfs_pkg::node_t'(i + 1));
        send_command(bfs_pkg::CMD_FIND, 6'd0, 6'd63);
        send_command(bfs_pkg::CMD_FIND, 6'd63, 6'd0);

        // random graphs, mostly small
        while (accepted < ITEMS) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 64) : $urandom_range(2, 12);
            graph_size = 0;
            build_graph(n, $urandom_range(n, 3 * n));
            cmds = $urandom_range(3, 8);
            for (int i = 0; i < cmds; i++) begin
                case ($urandom_range(0, 9))
                    0: send_command(bfs_pkg::CMD_ADD_EDGE, pick_node(), pick_node());
                    1: begin
                        send_command(bfs_pkg::CMD_ADD_VERT, bfs_pkg::node_t'($urandom_range(0, 63)),
                                     bfs_pkg::node_t'($urandom_range(0, 63)));
                        if (graph_size < MAX_NODES) graph_size++;
                    end
                    default: send_command(bfs_pkg::CMD_FIND, pick_node(), pick_node());
                endcase
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
